// ----- sv/lsac_pkg.sv -----
// lsac_pkg: sizes, status codes and shared structs for the associative cache
// no dependencies; every other file of the block imports it
`default_nettype none

package lsac_pkg;

  localparam int ENTRIES    = 32;
  localparam int KEY_BITS   = 64;
  localparam int STAMP_BITS = 32;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int SLOT_W     = 5;
  localparam int KEY_OUT_W  = 64;
  localparam int STATUS_W   = 3;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT     = 3'd0,
    ST_FILLED  = 3'd1,
    ST_EVICTED = 3'd2,
    ST_FAILED  = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  // sequencer to entry store
  typedef struct packed {
    logic   key_we;
    logic   stamp_we;
    idx_t   rd_addr;
    idx_t   wr_addr;
    key_t   wr_key;
    stamp_t wr_stamp;
  } mem_req_t;

  typedef struct packed {
    status_t               status;
    logic [SLOT_W-1:0]     slot;
    logic [KEY_OUT_W-1:0]  evicted_key;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/lsac_if.sv -----
// lsac_req_if / lsac_res_if: valid-ready channels of the associative cache
// depends on lsac_pkg for field widths
`default_nettype none

interface lsac_req_if;
  import lsac_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [KEY_OUT_W-1:0] lookup_key;
  logic                 create_ok;

  modport source (output valid, output req_type, output lookup_key, output create_ok,
                  input ready);
  modport sink   (input valid, input req_type, input lookup_key, input create_ok,
                  output ready);
endinterface

interface lsac_res_if;
  import lsac_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [SLOT_W-1:0]    slot;
  logic [KEY_OUT_W-1:0] evicted_key;

  modport source (output valid, output status, output slot, output evicted_key,
                  input ready);
  modport sink   (input valid, input status, input slot, input evicted_key,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/lsac_store.sv -----
// lsac_store: key and stamp memories, one write and one registered read port each
// depends on lsac_pkg
`default_nettype none

module lsac_store (
  input  wire                logic clk,
  input  lsac_pkg::mem_req_t req,
  output lsac_pkg::key_t     rd_key,
  output lsac_pkg::stamp_t   rd_stamp
);
  import lsac_pkg::*;

  key_t   key_mem   [ENTRIES];
  stamp_t stamp_mem [ENTRIES];
  key_t   rd_key_r;
  stamp_t rd_stamp_r;

  always_ff @(posedge clk) begin
    if (req.key_we) begin
      key_mem[req.wr_addr] <= req.wr_key;
    end
    rd_key_r <= key_mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (req.stamp_we) begin
      stamp_mem[req.wr_addr] <= req.wr_stamp;
    end
    rd_stamp_r <= stamp_mem[req.rd_addr];
  end

  assign rd_key   = rd_key_r;
  assign rd_stamp = rd_stamp_r;

endmodule

`default_nettype wire

// ----- sv/lsac_seq.sv -----
// lsac_seq: sequencer with the shared compare unit; scans entries, picks the
// victim, writes key and stamp and sweeps stamps on counter wrap
// depends on lsac_pkg and lsac_req_if
`default_nettype none

module lsac_seq (
  input  wire                logic clk,
  input  wire                logic rst_n,
  lsac_req_if.sink           req,
  output lsac_pkg::mem_req_t mem_req,
  input  lsac_pkg::key_t     rd_key,
  input  lsac_pkg::stamp_t   rd_stamp,
  output logic               res_valid,
  output lsac_pkg::result_t  res,
  input  wire                logic res_ready,
  output lsac_pkg::cnt_t     filled_cnt
);
  import lsac_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_WRITE  = 5'b00100,
    S_SWEEP  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t  state_r, state_nxt;
  cnt_t    filled_r, filled_nxt;
  stamp_t  cur_stamp_r, cur_stamp_nxt;
  logic    cmp_v_r, cmp_v_nxt;

  key_t    key_r, key_nxt;
  logic    create_r, create_nxt;
  cnt_t    scan_idx_r, scan_idx_nxt;
  idx_t    cmp_idx_r, cmp_idx_nxt;
  stamp_t  min_stamp_r, min_stamp_nxt;
  idx_t    min_idx_r, min_idx_nxt;
  key_t    min_key_r, min_key_nxt;
  status_t status_r, status_nxt;
  idx_t    slot_r, slot_nxt;
  key_t    evkey_r, evkey_nxt;
  cnt_t    sweep_idx_r, sweep_idx_nxt;

  logic key_eq;
  logic hit_now;
  logic issue;
  logic scan_done;

  assign req.ready = (state_r == S_IDLE);
  assign key_eq    = (rd_key == key_r);
  assign hit_now   = cmp_v_r && key_eq;
  assign issue     = (state_r == S_SCAN) && (scan_idx_r < filled_r);
  // last read has come back without a match
  assign scan_done = (state_r == S_SCAN) && !cmp_v_r && (scan_idx_r == filled_r);

  always_comb begin
    state_nxt     = state_r;
    filled_nxt    = filled_r;
    cur_stamp_nxt = cur_stamp_r;
    cmp_v_nxt     = issue;
    cmp_idx_nxt   = scan_idx_r[IDX_W-1:0];
    key_nxt       = key_r;
    create_nxt    = create_r;
    scan_idx_nxt  = scan_idx_r;
    min_stamp_nxt = min_stamp_r;
    min_idx_nxt   = min_idx_r;
    min_key_nxt   = min_key_r;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    evkey_nxt     = evkey_r;
    sweep_idx_nxt = sweep_idx_r;
    res_valid     = 1'b0;

    mem_req          = '0;
    mem_req.rd_addr  = scan_idx_r[IDX_W-1:0];
    mem_req.wr_key   = key_r;

    case (state_r)
      S_IDLE: begin
        if (req.valid) begin
          key_nxt      = req.lookup_key[KEY_BITS-1:0];
          create_nxt   = req.create_ok;
          scan_idx_nxt = '0;
          if (req.req_type) begin
            filled_nxt = '0;
            status_nxt = ST_CLEARED;
            slot_nxt   = '0;
            evkey_nxt  = '0;
            state_nxt  = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        // running minimum, lowest index wins ties
        if (cmp_v_r && !key_eq) begin
          if ((cmp_idx_r == '0) || (rd_stamp < min_stamp_r)) begin
            min_stamp_nxt = rd_stamp;
            min_idx_nxt   = cmp_idx_r;
            min_key_nxt   = rd_key;
          end
        end
        if (hit_now) begin
          status_nxt = ST_HIT;
          slot_nxt   = cmp_idx_r;
          evkey_nxt  = '0;
          state_nxt  = S_WRITE;
        end else if (scan_done) begin
          if (!create_r) begin
            status_nxt = ST_FAILED;
            slot_nxt   = '0;
            evkey_nxt  = '0;
            state_nxt  = S_FINISH;
          end else if (filled_r < CNT_W'(ENTRIES)) begin
            status_nxt = ST_FILLED;
            slot_nxt   = filled_r[IDX_W-1:0];
            evkey_nxt  = '0;
            filled_nxt = filled_r + 1'b1;
            state_nxt  = S_WRITE;
          end else begin
            status_nxt = ST_EVICTED;
            slot_nxt   = min_idx_r;
            evkey_nxt  = min_key_r;
            state_nxt  = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        mem_req.stamp_we = 1'b1;
        mem_req.key_we   = (status_r != ST_HIT);
        mem_req.wr_addr  = slot_r;
        mem_req.wr_stamp = cur_stamp_r;
        cur_stamp_nxt    = cur_stamp_r + 1'b1;
        if (cur_stamp_r == '1) begin
          sweep_idx_nxt = '0;
          state_nxt     = S_SWEEP;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SWEEP: begin
        // counter wrapped: zero every filled stamp
        mem_req.stamp_we = 1'b1;
        mem_req.wr_addr  = sweep_idx_r[IDX_W-1:0];
        mem_req.wr_stamp = '0;
        sweep_idx_nxt    = sweep_idx_r + 1'b1;
        if (cnt_t'(sweep_idx_r + 1'b1) == filled_r) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      filled_r    <= '0;
      cur_stamp_r <= '0;
      cmp_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      cur_stamp_r <= cur_stamp_nxt;
      cmp_v_r     <= cmp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    create_r    <= create_nxt;
    scan_idx_r  <= scan_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    min_stamp_r <= min_stamp_nxt;
    min_idx_r   <= min_idx_nxt;
    min_key_r   <= min_key_nxt;
    status_r    <= status_nxt;
    slot_r      <= slot_nxt;
    evkey_r     <= evkey_nxt;
    sweep_idx_r <= sweep_idx_nxt;
  end

  assign res.status      = status_r;
  assign res.slot        = SLOT_W'(slot_r);
  assign res.evicted_key = KEY_OUT_W'(evkey_r);
  assign filled_cnt      = filled_r;

endmodule

`default_nettype wire

// ----- sv/lru_stamp_assoc_cache_unit.sv -----
// Fully associative cache of 32 keys with timestamp LRU replacement. One request
// is taken at a time; in_req.ready is high only while the sequencer is idle. A
// clear goes from accept straight to the result. A lookup that misses runs the
// accept, one pass over the filled entries through the single read port of the
// key/stamp store with a registered read of each entry and a close of the pass,
// a write of key and stamp, then the result. A hit ends the pass at the matching
// entry, and a create-failed result skips the write. When the stamp counter
// wraps, a sweep over the filled entries zeroes the stored stamps before the
// result. The result sits in an output register, so the next request is taken
// while it waits. No clearing pass runs after reset.
// depends on lsac_pkg, lsac_if, lsac_store and lsac_seq
`default_nettype none

module lru_stamp_assoc_cache_unit (
  input  wire        logic clk,
  input  wire        logic rst_n,
  lsac_req_if.sink   in_req,
  lsac_res_if.source out_res
);
  import lsac_pkg::*;

  mem_req_t mem_req;
  key_t     rd_key;
  stamp_t   rd_stamp;
  logic     res_valid;
  result_t  res;
  logic     res_ready;
  cnt_t     filled_cnt;

  logic     out_v_r, out_v_nxt;
  result_t  out_word_r, out_word_nxt;

  lsac_store u_store (
    .clk      (clk),
    .req      (mem_req),
    .rd_key   (rd_key),
    .rd_stamp (rd_stamp)
  );

  lsac_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (in_req),
    .mem_req    (mem_req),
    .rd_key     (rd_key),
    .rd_stamp   (rd_stamp),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .filled_cnt (filled_cnt)
  );

  // output register frees the sequencer once the word is parked
  assign res_ready = !out_v_r || out_res.ready;

  always_comb begin
    out_v_nxt    = out_v_r;
    out_word_nxt = out_word_r;
    if (res_valid && res_ready) begin
      out_v_nxt    = 1'b1;
      out_word_nxt = res;
    end else if (out_res.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_res.valid       = out_v_r;
  assign out_res.status      = out_word_r.status;
  assign out_res.slot        = out_word_r.slot;
  assign out_res.evicted_key = out_word_r.evicted_key;

  a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.status == ST_EVICTED)) |-> (filled_cnt == CNT_W'(ENTRIES)))
    else $error("eviction reported while cache not full");

  a_evkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.status != ST_EVICTED)) |-> (res.evicted_key == '0))
    else $error("evicted key nonzero without eviction");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request taken while sequencer busy");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_cnt <= CNT_W'(ENTRIES))
    else $error("fill count beyond entry count");

endmodule

`default_nettype wire
